### rtl/ppsp_pkg.sv
// Package: constants, types and helper functions for the periodic pin sampler packer.
package ppsp_pkg;

    localparam int PIN_COUNT     = 48;
    localparam int PIN_AW        = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam int LEVEL_BITS    = 48;
    localparam int FRAME_WRAP    = 240;
    localparam int BITS_PER_BYTE = 8;
    localparam int MAX_BITS      = 48;
    localparam int MAX_BYTES     = MAX_BITS / BITS_PER_BYTE;

    typedef logic [PIN_AW-1:0] t_pin_addr;
    typedef logic [7:0]        t_byte;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_EMIT
    } t_state;

    typedef enum logic {
        CMD_SET  = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef struct packed {
        logic      en;
        t_pin_addr addr;
        t_byte     data;
    } t_tbl_wr;

    // One pipeline stage of the remainder by a nonzero divisor: shifts four dividend bits
    // into a partial remainder that is already below the divisor.
    function automatic t_byte f_mod_step4(input t_byte rem_in, input logic [3:0] a,
                                          input t_byte d);
        logic [8:0] rem;
        rem = {1'b0, rem_in};
        for (int i = 3; i >= 0; i--) begin
            rem = {rem[7:0], a[i]};
            if (rem >= {1'b0, d}) begin
                rem = rem - {1'b0, d};
            end
        end
        return rem[7:0];
    endfunction

    function automatic t_byte f_frame_next(input t_byte f);
        logic [8:0] s;
        s = {1'b0, f} + 9'd1;
        return (s >= 9'(FRAME_WRAP)) ? 8'd0 : s[7:0];
    endfunction

endpackage

### rtl/ppsp_if.sv
// Interfaces: request channel and report byte channel.
interface ppsp_in_if
    import ppsp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [5:0]            pin_index;
    logic [7:0]            divider;
    logic [LEVEL_BITS-1:0] pin_levels;

    modport source (output valid, command, pin_index, divider, pin_levels, input ready);
    modport sink   (input valid, command, pin_index, divider, pin_levels, output ready);
endinterface

interface ppsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_byte;
    logic [2:0] byte_position;
    logic       last;

    modport source (output valid, report_byte, byte_position, last, input ready);
    modport sink   (input valid, report_byte, byte_position, last, output ready);
endinterface

### rtl/ppsp_table.sv
// Divider table: synchronous memory with per-pin enable bits and enabled pin count.
module ppsp_table
    import ppsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tbl_wr   i_wr,
    input  t_pin_addr i_rd_addr,
    output t_byte     o_rd_data,
    output logic [6:0] o_enabled_count
);

    t_byte                mem [PIN_COUNT];
    t_byte                r_rd_raw;
    logic                 r_rd_on;
    logic [PIN_COUNT-1:0] r_on;
    logic [PIN_COUNT-1:0] n_on;
    logic [6:0]           r_count;
    logic [6:0]           n_count;
    logic                 old_on;
    logic                 new_on;

    always_comb begin
        n_on    = r_on;
        n_count = r_count;
        old_on  = r_on[i_wr.addr];
        new_on  = (i_wr.data != 8'd0);
        if (i_wr.en) begin
            n_on[i_wr.addr] = new_on;
            if (new_on && !old_on) begin
                n_count = r_count + 7'd1;
            end else if (!new_on && old_on) begin
                n_count = r_count - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on    <= '0;
            r_count <= '0;
            r_rd_on <= 1'b0;
        end else begin
            r_on    <= n_on;
            r_count <= n_count;
            r_rd_on <= r_on[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_raw <= mem[i_rd_addr];
    end

    assign o_rd_data       = r_rd_on ? r_rd_raw : 8'd0;
    assign o_enabled_count = r_count;

endmodule

### rtl/periodic_pin_sampler_packer_core.sv
// Top level: periodic pin sampler that packs captured levels into report bytes.
//
//   Channel  Direction  Payload                                 Handshake
//   i_req    in         command, pin_index, divider, pin_levels valid/ready
//   o_rsp    out        report_byte, byte_position, last        valid/ready
//
// A tick with at least one pin enabled walks the divider table one pin per cycle
// through its single read port; the remainder of the frame number by each divider is
// formed four bits per stage in two pipeline stages. The scan is followed by up to
// seven report bytes, each held until the output takes it. Reset clears the enable
// bits at once, no clearing pass.
// Requests are accepted only when the block is idle; a stalled output holds its byte.
module periodic_pin_sampler_packer_core
    import ppsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppsp_in_if.sink    i_req,
    ppsp_out_if.source o_rsp
);

    t_state                r_state, n_state;
    t_pin_addr             r_addr, n_addr;
    logic                  r_rd_valid, n_rd_valid;
    t_pin_addr             r_rd_pin, n_rd_pin;
    logic                  r_mod_valid, n_mod_valid;
    t_byte                 r_mod_rem, n_mod_rem;
    t_byte                 r_mod_div, n_mod_div;
    t_pin_addr             r_mod_pin, n_mod_pin;
    logic [LEVEL_BITS-1:0] r_levels, n_levels;
    t_byte                 r_frame, n_frame;
    logic [5:0]            r_bits, n_bits;
    logic [MAX_BYTES-1:0][7:0] r_packed, n_packed;
    logic [2:0]            r_pos, n_pos;
    logic                  r_out_valid, n_out_valid;
    t_byte                 r_out_byte, n_out_byte;
    logic [2:0]            r_out_pos, n_out_pos;
    logic                  r_out_last, n_out_last;

    t_tbl_wr    tbl_wr;
    t_byte      rd_data;
    logic [6:0] enabled_count;
    logic       accept;
    logic       hit;
    logic       level;
    logic [5:0] pin6;
    logic [5:0] bits_final;
    logic [2:0] nbytes;
    logic [2:0] byte_idx;
    logic       load;
    logic       is_last;

    ppsp_table u_table (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (tbl_wr),
        .i_rd_addr       (r_addr),
        .o_rd_data       (rd_data),
        .o_enabled_count (enabled_count)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        tbl_wr.en   = accept && (t_cmd'(i_req.command) == CMD_SET) &&
                      ({1'b0, i_req.pin_index} < 7'(PIN_COUNT));
        tbl_wr.addr = PIN_AW'(i_req.pin_index);
        tbl_wr.data = i_req.divider;
    end

    assign n_mod_valid = r_rd_valid && (rd_data != 8'd0);
    assign n_mod_rem   = f_mod_step4(8'd0, r_frame[7:4], rd_data);
    assign n_mod_div   = rd_data;
    assign n_mod_pin   = r_rd_pin;

    assign pin6   = 6'(r_mod_pin);
    assign level  = (pin6 < 6'(LEVEL_BITS)) ? r_levels[pin6] : 1'b0;
    assign hit    = r_mod_valid &&
                    (f_mod_step4(r_mod_rem, r_frame[3:0], r_mod_div) == 8'd0) &&
                    (r_bits < 6'(MAX_BITS));
    assign bits_final = hit ? (r_bits + 6'd1) : r_bits;
    assign nbytes   = 3'((7'(r_bits) + 7'd7) >> 3);
    assign byte_idx = r_pos - 3'd1;
    assign is_last  = (r_pos == nbytes);
    assign load     = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_rd_valid  = (r_state == S_SCAN);
        n_rd_pin    = r_addr;
        n_levels    = r_levels;
        n_frame     = r_frame;
        n_bits      = r_bits;
        n_packed    = r_packed;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_byte  = r_out_byte;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;

        if (hit) begin
            n_packed[r_bits[5:3]][r_bits[2:0]] = level;
            n_bits = r_bits + 6'd1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept && (t_cmd'(i_req.command) == CMD_TICK) &&
                    (enabled_count != 7'd0)) begin
                    n_addr   = '0;
                    n_levels = i_req.pin_levels;
                    n_bits   = '0;
                    n_packed = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == PIN_AW'(PIN_COUNT - 1)) begin
                    n_state = S_LAST;
                end else begin
                    n_addr = r_addr + PIN_AW'(1);
                end
            end
            S_LAST: begin
                n_pos = '0;
                if (!r_rd_valid) begin
                    if (bits_final == 6'd0) begin
                        n_frame = f_frame_next(r_frame);
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_pos;
                    n_out_byte  = (r_pos == 3'd0) ? r_frame : r_packed[byte_idx];
                    n_out_last  = is_last;
                    if (is_last) begin
                        n_frame = f_frame_next(r_frame);
                        n_state = S_IDLE;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_valid  <= 1'b0;
            r_mod_valid <= 1'b0;
            r_frame     <= '0;
            r_bits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_valid  <= n_rd_valid;
            r_mod_valid <= n_mod_valid;
            r_frame     <= n_frame;
            r_bits      <= n_bits;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_rd_pin   <= n_rd_pin;
        r_mod_rem  <= n_mod_rem;
        r_mod_div  <= n_mod_div;
        r_mod_pin  <= n_mod_pin;
        r_levels   <= n_levels;
        r_packed   <= n_packed;
        r_pos      <= n_pos;
        r_out_byte <= n_out_byte;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.report_byte   = r_out_byte;
    assign o_rsp.byte_position = r_out_pos;
    assign o_rsp.last          = r_out_last;

    a_bits_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= 6'(MAX_BITS))
        else $error("captured bit count exceeds the report capacity");

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame < 8'(FRAME_WRAP))
        else $error("frame counter left its range");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) ##1 (r_state == S_EMIT) |-> (r_bits != 6'd0))
        else $error("report started with no captured bit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid &&
            $stable({o_rsp.report_byte, o_rsp.byte_position, o_rsp.last}))
        else $error("stalled report byte changed before it was taken");

endmodule

### verif/testbench.sv
// Testbench for the periodic pin sampler packer: predicted report bytes checked against the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ppsp_pkg::*;

    typedef struct packed {
        t_byte      data;
        logic [2:0] pos;
        logic       last;
    } t_report_byte;

    logic clk;
    logic rst_n;

    ppsp_in_if  req_if ();
    ppsp_out_if rsp_if ();

    periodic_pin_sampler_packer_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_byte        div_table [PIN_COUNT];
    t_byte        model_frame;
    int           enabled_pins;
    t_report_byte report_expect [$];

    bit tx_idle;
    bit rx_idle;
    int rx_hold;

    int mismatches;
    int n_sets;
    int n_ticks;
    int n_reports;
    int n_bytes;
    int longest_report;
    int frame_wraps;
    int report_len;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t: mismatch: %s", $realtime, what);
    endtask

    function automatic logic [LEVEL_BITS-1:0] random_levels();
        return LEVEL_BITS'({$urandom, $urandom});
    endfunction

    // Updates the local copy of the table and frame counter and queues the report bytes.
    function automatic void predict_request(input t_cmd cmd, input logic [5:0] pin,
                                            input t_byte div, input logic [LEVEL_BITS-1:0] lev);
        logic [MAX_BITS-1:0] cap_bits;
        int                  nbits;
        int                  nbytes;
        t_report_byte        rb;
        cap_bits = '0;
        nbits    = 0;
        if (cmd == CMD_SET) begin
            n_sets++;
            if (int'(pin) < PIN_COUNT) begin
                if (div != 0 && div_table[pin] == 0) begin
                    enabled_pins++;
                end else if (div == 0 && div_table[pin] != 0) begin
                    enabled_pins--;
                end
                div_table[pin] = div;
            end
            return;
        end
        n_ticks++;
        if (enabled_pins == 0) begin
            return;
        end
        for (int p = 0; p < PIN_COUNT; p++) begin
            if (div_table[p] != 0 && (int'(model_frame) % int'(div_table[p])) == 0
                    && nbits < MAX_BITS) begin
                if (p < LEVEL_BITS) begin
                    cap_bits[nbits] = lev[p];
                end
                nbits++;
            end
        end
        if (nbits != 0) begin
            nbytes = (nbits + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
            rb.data = model_frame;
            rb.pos  = 3'd0;
            rb.last = 1'b0;
            report_expect.push_back(rb);
            for (int k = 0; k < nbytes; k++) begin
                rb.data = cap_bits[k*BITS_PER_BYTE +: BITS_PER_BYTE];
                rb.pos  = 3'(k + 1);
                rb.last = (k == nbytes - 1);
                report_expect.push_back(rb);
            end
        end
        if (int'(model_frame) + 1 >= FRAME_WRAP) begin
            model_frame = '0;
            frame_wraps++;
        end else begin
            model_frame = model_frame + 8'd1;
        end
    endfunction

    // Offers one request and waits until the block takes it; valid stays high afterwards.
    task automatic send_request(input t_cmd cmd, input logic [5:0] pin, input t_byte div,
                                input logic [LEVEL_BITS-1:0] lev);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.command    <= cmd;
        req_if.pin_index  <= pin;
        req_if.divider    <= div;
        req_if.pin_levels <= lev;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        predict_request(cmd, pin, div, lev);
    endtask

    initial begin
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            int gap;
            gap = rx_idle ? $urandom_range(0, 7) : 0;
            if (rx_hold > 0) begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) @(posedge clk);
        end
    end

    initial begin
        t_report_byte rb;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                n_bytes++;
                report_len++;
                if (rsp_if.last === 1'b1) begin
                    n_reports++;
                    if (report_len > longest_report) begin
                        longest_report = report_len;
                    end
                    report_len = 0;
                end
                if (report_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected report byte %02h at position %0d",
                                              rsp_if.report_byte, rsp_if.byte_position));
                end else begin
                    rb = report_expect.pop_front();
                    if (rsp_if.report_byte !== rb.data) begin
                        report_mismatch($sformatf("report_byte %02h, expected %02h (position %0d)",
                                                  rsp_if.report_byte, rb.data, rb.pos));
                    end
                    if (rsp_if.byte_position !== rb.pos) begin
                        report_mismatch($sformatf("byte_position %0d, expected %0d",
                                                  rsp_if.byte_position, rb.pos));
                    end
                    if (rsp_if.last !== rb.last) begin
                        report_mismatch($sformatf("last %b, expected %b (position %0d)",
                                                  rsp_if.last, rb.last, rb.pos));
                    end
                end
            end
        end
    end

    task automatic test_stopped_timer();
        send_request(CMD_TICK, 6'd0, 8'd0, '1);
        send_request(CMD_TICK, 6'd63, 8'd255, '0);
        send_request(CMD_SET, 6'd48, 8'd255, '0);
        send_request(CMD_SET, 6'd63, 8'd1, '1);
        send_request(CMD_TICK, 6'd0, 8'd0, '1);
    endtask

    task automatic test_single_pins();
        send_request(CMD_SET, 6'd0, 8'd1, '0);
        send_request(CMD_TICK, 6'd0, 8'd0, '1);
        send_request(CMD_SET, 6'd47, 8'd255, '0);
        send_request(CMD_TICK, 6'd0, 8'd0, '0);
        send_request(CMD_TICK, 6'd0, 8'd0, '1);
        send_request(CMD_SET, 6'd0, 8'd2, '0);
        send_request(CMD_TICK, 6'd0, 8'd0, 48'h8000_0000_0001);
        send_request(CMD_TICK, 6'd0, 8'd0, '1);
        send_request(CMD_SET, 6'd0, 8'd0, '0);
        send_request(CMD_SET, 6'd47, 8'd0, '0);
    endtask

    task automatic test_no_capture();
        send_request(CMD_SET, 6'd10, 8'd200, '0);
        send_request(CMD_TICK, 6'd0, 8'd0, '1);
        send_request(CMD_TICK, 6'd0, 8'd0, '1);
        send_request(CMD_SET, 6'd10, 8'd0, '0);
        send_request(CMD_TICK, 6'd0, 8'd0, '1);
    endtask

    // Enables every pin so that reports on even frames reach seven bytes, then stalls the output for a while.
    task automatic test_full_report();
        tx_idle = 1'b0;
        for (int p = 0; p < PIN_COUNT; p++) begin
            send_request(CMD_SET, 6'(p), ($urandom_range(0, 3) == 0) ? 8'd2 : 8'd1, '0);
        end
        rx_hold = 200;
        repeat (6) send_request(CMD_TICK, 6'($urandom), t_byte'($urandom), random_levels());
        tx_idle = 1'b1;
    endtask

    task automatic test_random_traffic(input int n_items, input bit idle_on);
        t_byte div;
        tx_idle = idle_on;
        rx_idle = idle_on;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: div = 8'd0;
                    1: div = t_byte'($urandom_range(1, 4));
                    2: div = 8'd255;
                    default: div = t_byte'($urandom);
                endcase
                send_request(CMD_SET, 6'($urandom), div, random_levels());
            end else begin
                send_request(CMD_TICK, 6'($urandom), t_byte'($urandom), random_levels());
            end
        end
    endtask

    initial begin
        rst_n             <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.command    <= CMD_SET;
        req_if.pin_index  <= '0;
        req_if.divider    <= '0;
        req_if.pin_levels <= '0;
        for (int p = 0; p < PIN_COUNT; p++) begin
            div_table[p] = '0;
        end
        model_frame  = '0;
        enabled_pins = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        rx_hold      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stopped_timer();
        test_single_pins();
        test_no_capture();
        test_full_report();
        test_random_traffic(70, 1'b0);
        test_random_traffic(136, 1'b1);

        req_if.valid <= 1'b0;
        @(posedge clk);
        while (report_expect.size() != 0) @(posedge clk);
        repeat (PIN_COUNT + 16) @(posedge clk);

        $display("Run covered %0d set and %0d tick requests, %0d reports of %0d bytes in total.",
                 n_sets, n_ticks, n_reports, n_bytes);
        $display("The longest report had %0d bytes and the frame counter wrapped %0d times.",
                 longest_report, frame_wraps);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
